/* rtl/assert_macros.svh */
// Assertion macros shared by the allocator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies another in the same cycle.
`define BPA_ASSERT_IMPLY(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("allocator check failed");

// Checks that a condition implies another in the following cycle.
`define BPA_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("allocator check failed");

`endif

/* rtl/bpa_pkg.sv */
// Package with types, codes and geometry helpers for the buddy page allocator.
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int NUM_PAGES_DEF = 4096;
  localparam int MAX_ORDER_DEF = 10;
  localparam int WORD_BITS     = 32;
  localparam int BIT_W         = 5;
  localparam int PAGE_SHIFT    = 12;
  localparam int RES_W         = 13;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_INIT  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EXHAUST  = 2'd1;
  localparam logic [1:0] ST_BAD_SIZE = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] size_pages;
    logic [23:0] block_address;
  } bpa_cmd_t;

  typedef struct packed {
    logic [23:0] address;
    logic [1:0]  status;
  } bpa_result_t;

  typedef enum logic [1:0] {
    WOP_ZERO,
    WOP_SET_A,
    WOP_CLR_A,
    WOP_CLR_AB
  } bpa_wop_t;

  typedef struct packed {
    logic             any;
    logic [BIT_W-1:0] first;
    logic             b_set;
  } bpa_wres_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_CARVE_RD,
    S_CARVE_WR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SPLIT_RD,
    S_SPLIT_WR,
    S_FREE_RD,
    S_FREE_CHK,
    S_FIN
  } bpa_state_t;

  // Number of 32-bit words that hold the free bits of one order.
  function automatic int words_in(int np, int k);
    return ((np >> k) + WORD_BITS - 1) >> BIT_W;
  endfunction

  // First word of an order's region in the bit store.
  function automatic int word_base(int np, int k);
    int b;
    b = 0;
    for (int i = 0; i < 18; i++) begin
      if (i < k) b += words_in(np, i);
    end
    return b;
  endfunction

endpackage

/* rtl/bpa_store.sv */
// Free bit store: one word written and one word read per cycle, read data registered.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bpa_store import bpa_pkg::*; #(
  parameter int WORDS = 258,
  parameter int AW    = 9
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic [AW-1:0]        raddr,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  `BPA_ASSERT_IMPLY(a_waddr_range, we, 32'(waddr) < WORDS)

endmodule

/* rtl/bpa_word_unit.sv */
// Shared word unit: finds the first free bit, tests a bit and edits bits of one word.
`timescale 1ns / 1ps
module bpa_word_unit import bpa_pkg::*; (
  input  logic [WORD_BITS-1:0] word,
  input  bpa_wop_t             op,
  input  logic [BIT_W-1:0]     bit_a,
  input  logic [BIT_W-1:0]     bit_b,
  output logic [WORD_BITS-1:0] new_word,
  output bpa_wres_t            res
);

  always_comb begin
    res.any   = |word;
    res.first = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word[i]) res.first = BIT_W'(i);
    end
    res.b_set = word[bit_b];
  end

  always_comb begin
    new_word = word;
    unique case (op)
      WOP_ZERO:   new_word = '0;
      WOP_SET_A:  new_word[bit_a] = 1'b1;
      WOP_CLR_A:  new_word[bit_a] = 1'b0;
      WOP_CLR_AB: begin
        new_word[bit_a] = 1'b0;
        new_word[bit_b] = 1'b0;
      end
      default:    new_word = word;
    endcase
  end

endmodule

/* rtl/bpa_ctrl.sv */
// Sequencer of the allocator: clearing, carving, allocation scan, splits and merges.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bpa_ctrl import bpa_pkg::*; #(
  parameter int NUM_PAGES = NUM_PAGES_DEF,
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  parameter int WORDS     = 258,
  parameter int AW        = 9
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  bpa_cmd_t             cmd,
  input  logic [RES_W-1:0]     reserved,
  output logic                 busy,
  output logic                 result_valid,
  output bpa_result_t          result,
  output logic                 we,
  output logic [AW-1:0]        waddr,
  output logic [AW-1:0]        raddr,
  output bpa_wop_t             op,
  output logic [BIT_W-1:0]     bit_a,
  output logic [BIT_W-1:0]     bit_b,
  input  bpa_wres_t            wres
);

  localparam int PGW = $clog2(NUM_PAGES + 1);
  localparam int PW  = (PGW > PAGE_SHIFT) ? PGW : PAGE_SHIFT;
  localparam int OW  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER + 1) : 1;
  localparam int EW  = ((PW > MAX_ORDER) ? PW : MAX_ORDER) + 2;

  bpa_state_t       state, state_next;
  logic [AW-1:0]    wcnt, wcnt_next;
  logic             init, init_next;
  logic [OW-1:0]    k_req, k_req_next;
  logic [OW-1:0]    j, j_next;
  logic [AW-1:0]    wo, wo_next;
  logic [PW-1:0]    idx, idx_next;
  logic [PW-1:0]    page, page_next;
  logic [PW-1:0]    p, p_next;
  logic [OW-1:0]    ck, ck_next;
  bpa_result_t      res, res_next;

  logic [3:0]       korder;
  logic             bad_size;
  logic [PW-1:0]    page_in;
  logic [PW-1:0]    free_idx;
  logic [OW-1:0]    cc;
  logic [PW-1:0]    idx_found;
  logic [PW-1:0]    page_found;
  logic [PW-1:0]    split_idx;
  logic [PW-1:0]    carve_idx;
  logic [OW-1:0]    ord_sel;
  logic [AW-1:0]    woff_sel;
  logic [AW-1:0]    mem_addr;
  logic [EW-1:0]    p_sum;
  logic [PW-1:0]    p_start;

  // Request decode.
  always_comb begin
    bad_size = (cmd.size_pages == '0) ||
               (32'(cmd.size_pages) > (32'd1 << MAX_ORDER));
    korder = '0;
    for (int c = 11; c >= 0; c--) begin
      if ((12'd1 << c) >= {1'b0, cmd.size_pages}) korder = 4'(c);
    end
    page_in  = PW'(cmd.block_address[23:PAGE_SHIFT]);
    free_idx = page_in >> OW'(korder);
  end

  // Largest aligned block that fits at the carve pointer.
  always_comb begin
    cc = '0;
    for (int c = 0; c <= MAX_ORDER; c++) begin
      if (((EW'(p) & ((EW'(1) << c) - EW'(1))) == '0) &&
          (EW'(p) + (EW'(1) << c) <= EW'(NUM_PAGES)))
        cc = OW'(c);
    end
  end

  assign idx_found  = PW'({wo, wres.first});
  assign page_found = idx_found << j;
  assign split_idx  = (page >> j) + PW'(1);
  assign carve_idx  = p >> ((state == S_CARVE_RD) ? cc : ck);
  assign p_sum      = EW'(p) + (EW'(1) << ck);
  assign p_start    = (32'(reserved) > NUM_PAGES) ? PW'(NUM_PAGES) : PW'(reserved);

  // Next state and datapath registers.
  always_comb begin
    state_next = state;
    wcnt_next  = wcnt;
    init_next  = init;
    k_req_next = k_req;
    j_next     = j;
    wo_next    = wo;
    idx_next   = idx;
    page_next  = page;
    p_next     = p;
    ck_next    = ck;
    res_next   = res;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          res_next.address = '0;
          res_next.status  = ST_OK;
          state_next       = S_FIN;
          priority if (cmd.kind == KIND_INIT) begin
            wcnt_next  = '0;
            init_next  = 1'b1;
            state_next = S_CLEAR;
          end else if (cmd.kind == KIND_ALLOC) begin
            if (bad_size) begin
              res_next.status = ST_BAD_SIZE;
            end else begin
              k_req_next = OW'(korder);
              j_next     = OW'(korder);
              wo_next    = '0;
              if (words_in(NUM_PAGES, int'(korder)) == 0) res_next.status = ST_EXHAUST;
              else state_next = S_SCAN_RD;
            end
          end else if (cmd.kind == KIND_FREE) begin
            if (bad_size) begin
              res_next.status = ST_BAD_SIZE;
            end else if (free_idx < (PW'(NUM_PAGES) >> OW'(korder))) begin
              j_next     = OW'(korder);
              idx_next   = free_idx;
              state_next = S_FREE_RD;
            end
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_CLEAR: begin
        wcnt_next = wcnt + AW'(1);
        if (32'(wcnt) == WORDS - 1) begin
          if (init) begin
            init_next  = 1'b0;
            p_next     = p_start;
            state_next = (32'(p_start) < NUM_PAGES) ? S_CARVE_RD : S_FIN;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_CARVE_RD: begin
        ck_next    = cc;
        state_next = S_CARVE_WR;
      end
      S_CARVE_WR: begin
        p_next     = PW'(p_sum);
        state_next = (p_sum >= EW'(NUM_PAGES)) ? S_FIN : S_CARVE_RD;
      end
      S_SCAN_RD: state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (wres.any) begin
          page_next        = page_found;
          res_next.address = {page_found[PAGE_SHIFT-1:0], PAGE_SHIFT'(0)};
          res_next.status  = ST_OK;
          if (j > k_req) begin
            j_next     = j - OW'(1);
            state_next = S_SPLIT_RD;
          end else begin
            state_next = S_FIN;
          end
        end else if (32'(wo) == words_in(NUM_PAGES, int'(j)) - 1) begin
          if ((32'(j) == MAX_ORDER) || (words_in(NUM_PAGES, int'(j) + 1) == 0)) begin
            res_next.status = ST_EXHAUST;
            state_next      = S_FIN;
          end else begin
            j_next     = j + OW'(1);
            wo_next    = '0;
            state_next = S_SCAN_RD;
          end
        end else begin
          wo_next    = wo + AW'(1);
          state_next = S_SCAN_RD;
        end
      end
      S_SPLIT_RD: state_next = S_SPLIT_WR;
      S_SPLIT_WR: begin
        if (j > k_req) begin
          j_next     = j - OW'(1);
          state_next = S_SPLIT_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FREE_RD: state_next = S_FREE_CHK;
      S_FREE_CHK: begin
        if ((32'(j) < MAX_ORDER) && wres.b_set) begin
          idx_next   = idx >> 1;
          j_next     = j + OW'(1);
          state_next = S_FREE_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Store address: one adder shared by every access but the clear sweep.
  always_comb begin
    ord_sel  = j;
    woff_sel = wo;
    unique case (state)
      S_CARVE_RD, S_CARVE_WR: begin
        ord_sel  = (state == S_CARVE_RD) ? cc : ck;
        woff_sel = AW'(carve_idx >> BIT_W);
      end
      S_SPLIT_RD, S_SPLIT_WR: woff_sel = AW'(split_idx >> BIT_W);
      S_FREE_RD, S_FREE_CHK:  woff_sel = AW'(idx >> BIT_W);
      default: woff_sel = wo;
    endcase
    mem_addr = AW'(word_base(NUM_PAGES, int'(ord_sel))) + woff_sel;
  end

  // Store and word unit controls.
  always_comb begin
    busy  = (state != S_IDLE);
    we    = 1'b0;
    op    = WOP_SET_A;
    bit_a = '0;
    bit_b = '0;
    raddr = mem_addr;
    waddr = mem_addr;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        op    = WOP_ZERO;
        waddr = wcnt;
      end
      S_CARVE_WR: begin
        we    = 1'b1;
        bit_a = carve_idx[BIT_W-1:0];
      end
      S_SCAN_CHK: begin
        we    = wres.any;
        op    = WOP_CLR_A;
        bit_a = wres.first;
      end
      S_SPLIT_WR: begin
        we    = 1'b1;
        bit_a = split_idx[BIT_W-1:0];
      end
      S_FREE_CHK: begin
        we    = 1'b1;
        bit_a = idx[BIT_W-1:0];
        bit_b = idx[BIT_W-1:0] ^ BIT_W'(1);
        op    = ((32'(j) < MAX_ORDER) && wres.b_set) ? WOP_CLR_AB : WOP_SET_A;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      wcnt         <= '0;
      init         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      wcnt         <= wcnt_next;
      init         <= init_next;
      result_valid <= (state == S_FIN);
    end
  end

  always_ff @(posedge clk) begin
    k_req <= k_req_next;
    j     <= j_next;
    wo    <= wo_next;
    idx   <= idx_next;
    page  <= page_next;
    p     <= p_next;
    ck    <= ck_next;
    res   <= res_next;
  end

  assign result = res;

  `BPA_ASSERT_IMPLY(a_result_idle, result_valid, !busy)
  `BPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `BPA_ASSERT_IMPLY(a_result_after_work, result_valid, $past(busy))

endmodule

/* rtl/buddy_page_allocator_unit.sv */
// Top level of the buddy page allocator: config register, sequencer, word unit and bit store.
// Allocate scans the store words of the requested order and up, then splits the block found;
// free sets the freed bit or merges it with a free buddy, level by level; initialize clears
// every store word (258 at the default size) and carves free blocks. One request at a time,
// limited by the single store port pair and the shared word unit. The receiver cannot stall.
// After reset the store is swept clear, one word after another, while busy is high.
`timescale 1ns / 1ps
module buddy_page_allocator_unit import bpa_pkg::*; #(
  parameter int NUM_PAGES = NUM_PAGES_DEF,
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bpa_cmd_t          cmd,
  output logic              result_valid,
  output bpa_result_t       result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [RES_W-1:0]  cfg_data
);

  // The free bits of all orders share one store of 32-bit words; each order
  // owns a contiguous region starting at word_base().
  localparam int WORDS = word_base(NUM_PAGES, MAX_ORDER + 1);
  localparam int AW    = $clog2(WORDS);

  logic [RES_W-1:0]     reserved;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] wdata;
  bpa_wop_t             op;
  logic [BIT_W-1:0]     bit_a;
  logic [BIT_W-1:0]     bit_b;
  bpa_wres_t            wres;

  // The reserve count is taken on every beat of the config channel; it is
  // only sampled when an initialize request starts its carve.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else if (cfg_valid && cfg_ready) begin
      reserved <= cfg_data;
    end
  end

  bpa_ctrl #(
    .NUM_PAGES(NUM_PAGES),
    .MAX_ORDER(MAX_ORDER),
    .WORDS(WORDS),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .reserved(reserved),
    .busy(busy),
    .result_valid(result_valid),
    .result(result),
    .we(we),
    .waddr(waddr),
    .raddr(raddr),
    .op(op),
    .bit_a(bit_a),
    .bit_b(bit_b),
    .wres(wres)
  );

  // The word unit edits the word read in the previous cycle; outside the clear
  // sweep its output is written back to the same store word.
  bpa_word_unit u_word (
    .word(rdata),
    .op(op),
    .bit_a(bit_a),
    .bit_b(bit_b),
    .new_word(wdata),
    .res(wres)
  );

  bpa_store #(
    .WORDS(WORDS),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .rst(rst),
    .we(we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

endmodule
